[hdl/htw_pkg.sv]
// Package for the hashed timing wheel: request and result item types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package htw_pkg;
   localparam int NumTimersDef  = 16;
   localparam int WheelSlotsDef = 256;
   localparam int ResultCap     = 16;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_STOP  = 2'd2;
   localparam logic [1:0] REQ_DRAIN = 2'd3;

   localparam logic [1:0] RSP_START = 2'd0;
   localparam logic [1:0] RSP_STOP  = 2'd1;
   localparam logic [1:0] RSP_EXPIRED = 2'd2;

   localparam logic [1:0] PLACE_IDLE  = 2'd0;
   localparam logic [1:0] PLACE_WHEEL = 2'd1;
   localparam logic [1:0] PLACE_PEND  = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  timer_index;
      logic [23:0] first_ms;
      logic [23:0] repeat_ms;
   } req_item_type;

   typedef struct packed {
      logic [1:0] resp_kind;
      logic [3:0] timer_out;
      logic       removed;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic        start;
      logic [23:0] dividend;
      logic [15:0] divisor;
   } div_cmd_type;
endpackage

[hdl/hashed_timing_wheel_unit.sv]
// Top level of the hashed timing wheel timer pool: sequencer, slot memory, timer tables.
// Depends on htw_pkg and htw_div.
//
// Use: requests enter on req_valid/req_stall with one req_item_type each; results leave on
// rsp_valid/rsp_stall as rsp_item_type. The tick period is written on csr_valid/csr_ready;
// the user must write it only while no request is in flight; the block leaves this unchecked.
// A tick gives no result; start and stop give one item; a drain gives one item per pending
// timer, at most 16, the final one flagged last. The block takes one request at a time and
// stalls its input meanwhile. A start runs two 24-step ceiling divisions on the shared
// divider. A tick walks one slot list, one timer at a time, and a stop or restart walks
// the list holding the timer, element by element.
// A drain reads the target slot and then relinks and reports each periodic timer, and
// reports each one-shot timer directly.
// After reset a clearing pass sweeps the slot memory, one slot a cycle, during which no
// request is taken. A stalled result is held in the output register and the sequencer
// waits for it to be taken before it writes the next result.
`timescale 1ns / 1ps
module hashed_timing_wheel_unit #(
   parameter int NUM_TIMERS  = htw_pkg::NumTimersDef,
   parameter int WHEEL_SLOTS = htw_pkg::WheelSlotsDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  htw_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output htw_pkg::rsp_item_type rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);
   localparam int TW = $clog2(NUM_TIMERS + 1);
   localparam int SW = (WHEEL_SLOTS > 2) ? $clog2(WHEEL_SLOTS) : 1;
   localparam logic [TW-1:0] EMPTY = TW'(NUM_TIMERS);
   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DIV_DLY, S_DIV_REP, S_UNLINK_RD, S_UNLINK_WALK,
      S_ARM, S_TICK_RD, S_TICK_WALK, S_DRAIN, S_RSP, S_DRAIN_RSP
   } state_type;

   state_type      state_ff;
   logic [15:0]    period_ff;
   htw_pkg::req_item_type req_ff;
   htw_pkg::rsp_item_type rsp_ff;
   logic           rsp_valid_ff;
   logic [SW-1:0]  ptr_ff, clr_ff;
   logic [TW-1:0]  pend_ff;
   logic [TW-1:0]  link_ff  [NUM_TIMERS];
   logic [SW-1:0]  eslot_ff [NUM_TIMERS];
   logic [15:0]    round_ff [NUM_TIMERS];
   logic [23:0]    eper_ff  [NUM_TIMERS];
   logic [1:0]     place_ff [NUM_TIMERS];
   logic [TW-1:0]  slot_mem [WHEEL_SLOTS];
   logic [TW-1:0]  slot_rd_ff;
   logic [TW-1:0]  cur_ff, prev_ff;
   logic [23:0]    dticks_ff;
   logic           rem_ff;
   logic [4:0]     cnt_ff;
   logic           wait_ff;
   logic [SW-1:0]  walk_slot_ff;
   logic           walk_pend_ff;

   htw_pkg::div_cmd_type div_cmd;
   logic           div_busy;
   logic [23:0]    div_q;

   htw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .busy     (div_busy),
      .quotient (div_q)
   );

   logic [IW-1:0] tidx, cidx;
   logic          idx_ok;
   assign tidx   = req_ff.timer_index[IW-1:0];
   assign idx_ok = ({1'b0, req_ff.timer_index} < 5'(NUM_TIMERS));
   assign cidx   = cur_ff[IW-1:0];

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // wheel placement of a tick count
   function automatic logic [15:0] rounds_of(input logic [23:0] t);
      logic [23:0] r;
      r = (t - 24'd1) >> SW;
      rounds_of = (r > 24'd65535) ? 16'hFFFF : r[15:0];
   endfunction

   logic [23:0] arm_ticks;
   logic [SW-1:0] arm_slot;
   always_comb begin
      arm_ticks = (state_ff == S_DRAIN) ? eper_ff[cidx] : dticks_ff;
      arm_slot  = ptr_ff + arm_ticks[SW-1:0];
   end

   always_comb begin
      div_cmd = '0;
      if (state_ff == S_IDLE && req_valid && req_item.req_type == htw_pkg::REQ_START) begin
         div_cmd.start    = 1'b1;
         div_cmd.dividend = req_item.first_ms;
         div_cmd.divisor  = period_ff;
      end else if (state_ff == S_DIV_DLY && !wait_ff && !div_busy) begin
         div_cmd.start    = 1'b1;
         div_cmd.dividend = req_ff.repeat_ms;
         div_cmd.divisor  = period_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         period_ff    <= 16'd1;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         clr_ff       <= '0;
         pend_ff      <= EMPTY;
         wait_ff      <= 1'b0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            place_ff[i] <= htw_pkg::PLACE_IDLE;
         end
      end else begin
         if (csr_valid) begin
            period_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         wait_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               slot_mem[clr_ff] <= EMPTY;
               clr_ff <= clr_ff + SW'(1);
               if (clr_ff == SW'(WHEEL_SLOTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff  <= req_item;
                  rem_ff  <= 1'b0;
                  cnt_ff  <= '0;
                  prev_ff <= EMPTY;
                  case (req_item.req_type)
                     htw_pkg::REQ_TICK: begin
                        ptr_ff   <= ptr_ff + SW'(1);
                        state_ff <= S_TICK_RD;
                     end
                     htw_pkg::REQ_START: begin
                        wait_ff  <= 1'b1;
                        state_ff <= S_DIV_DLY;
                     end
                     htw_pkg::REQ_STOP:  state_ff <= S_UNLINK_RD;
                     default: begin
                        cur_ff   <= pend_ff;
                        state_ff <= S_DRAIN;
                     end
                  endcase
               end
            end
            S_DIV_DLY: begin
               if (!wait_ff && !div_busy) begin
                  dticks_ff <= div_q;
                  wait_ff   <= 1'b1;
                  state_ff  <= S_DIV_REP;
               end
            end
            S_DIV_REP: begin
               if (!wait_ff && !div_busy) begin
                  if (idx_ok) begin
                     eper_ff[tidx] <= div_q;
                  end
                  wait_ff  <= 1'b1;
                  state_ff <= S_UNLINK_RD;
               end
            end
            S_UNLINK_RD: begin
               prev_ff <= EMPTY;
               if (!idx_ok || place_ff[tidx] == htw_pkg::PLACE_IDLE) begin
                  state_ff <= (req_ff.req_type == htw_pkg::REQ_START && idx_ok)
                              ? S_ARM : S_RSP;
               end else begin
                  rem_ff       <= 1'b1;
                  walk_pend_ff <= (place_ff[tidx] == htw_pkg::PLACE_PEND);
                  walk_slot_ff <= eslot_ff[tidx];
                  slot_rd_ff   <= slot_mem[eslot_ff[tidx]];
                  wait_ff      <= 1'b1;
                  state_ff     <= S_UNLINK_WALK;
               end
            end
            S_UNLINK_WALK: begin
               if (wait_ff) begin
                  cur_ff <= walk_pend_ff ? pend_ff : slot_rd_ff;
               end else if (cur_ff == EMPTY) begin
                  place_ff[tidx] <= htw_pkg::PLACE_IDLE;
                  state_ff <= (req_ff.req_type == htw_pkg::REQ_START) ? S_ARM : S_RSP;
               end else if (cidx == tidx) begin
                  if (prev_ff == EMPTY) begin
                     if (walk_pend_ff) pend_ff <= link_ff[cidx];
                     else slot_mem[walk_slot_ff] <= link_ff[cidx];
                  end else begin
                     link_ff[prev_ff[IW-1:0]] <= link_ff[cidx];
                  end
                  place_ff[tidx] <= htw_pkg::PLACE_IDLE;
                  state_ff <= (req_ff.req_type == htw_pkg::REQ_START) ? S_ARM : S_RSP;
               end else begin
                  prev_ff <= cur_ff;
                  cur_ff  <= link_ff[cidx];
               end
            end
            S_ARM: begin
               if (dticks_ff == 24'd0) begin
                  link_ff[tidx]  <= pend_ff;
                  pend_ff        <= TW'(tidx);
                  place_ff[tidx] <= htw_pkg::PLACE_PEND;
                  state_ff       <= S_RSP;
               end else if (wait_ff == 1'b0 && cnt_ff == 5'd0) begin
                  slot_rd_ff <= slot_mem[arm_slot];
                  cnt_ff     <= 5'd1;
               end else begin
                  link_ff[tidx]     <= slot_rd_ff;
                  slot_mem[arm_slot] <= TW'(tidx);
                  eslot_ff[tidx]    <= arm_slot;
                  round_ff[tidx]    <= rounds_of(dticks_ff);
                  place_ff[tidx]    <= htw_pkg::PLACE_WHEEL;
                  state_ff          <= S_RSP;
               end
            end
            S_RSP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.resp_kind  <= (req_ff.req_type == htw_pkg::REQ_START)
                                       ? htw_pkg::RSP_START : htw_pkg::RSP_STOP;
                  rsp_ff.timer_out  <= req_ff.timer_index;
                  rsp_ff.removed    <= rem_ff;
                  rsp_ff.last       <= 1'b1;
                  state_ff          <= S_IDLE;
               end
            end
            S_TICK_RD: begin
               slot_rd_ff <= slot_mem[ptr_ff];
               wait_ff    <= 1'b0;
               cnt_ff     <= '0;
               state_ff   <= S_TICK_WALK;
               cur_ff     <= EMPTY;
               prev_ff    <= EMPTY;
            end
            S_TICK_WALK: begin
               if (cnt_ff == 5'd0) begin
                  cur_ff <= slot_rd_ff;
                  cnt_ff <= 5'd1;
               end else if (cur_ff == EMPTY || cnt_ff > 5'(NUM_TIMERS)) begin
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
                  cur_ff <= link_ff[cidx];
                  if (round_ff[cidx] != 16'd0) begin
                     round_ff[cidx] <= round_ff[cidx] - 16'd1;
                     prev_ff <= cur_ff;
                  end else begin
                     if (prev_ff == EMPTY) slot_mem[ptr_ff] <= link_ff[cidx];
                     else link_ff[prev_ff[IW-1:0]] <= link_ff[cidx];
                     link_ff[cidx]  <= pend_ff;
                     pend_ff        <= cur_ff;
                     place_ff[cidx] <= htw_pkg::PLACE_PEND;
                  end
               end
            end
            S_DRAIN: begin
               if (cur_ff == EMPTY || cnt_ff == 5'(htw_pkg::ResultCap)) begin
                  pend_ff  <= cur_ff;
                  state_ff <= S_IDLE;
               end else if (eper_ff[cidx] != 24'd0 && !wait_ff) begin
                  slot_rd_ff <= slot_mem[arm_slot];
                  wait_ff    <= 1'b1;
                  state_ff   <= S_DRAIN;
               end else if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_ff.resp_kind <= htw_pkg::RSP_EXPIRED;
                  rsp_ff.timer_out <= 4'(cur_ff);
                  rsp_ff.removed   <= 1'b0;
                  rsp_ff.last      <= (link_ff[cidx] == EMPTY)
                                      || (cnt_ff == 5'(htw_pkg::ResultCap - 1));
                  cnt_ff <= cnt_ff + 5'd1;
                  cur_ff <= link_ff[cidx];
                  if (eper_ff[cidx] != 24'd0) begin
                     link_ff[cidx]      <= slot_rd_ff;
                     slot_mem[arm_slot] <= cur_ff;
                     eslot_ff[cidx]     <= arm_slot;
                     round_ff[cidx]     <= rounds_of(eper_ff[cidx]);
                     place_ff[cidx]     <= htw_pkg::PLACE_WHEEL;
                  end else begin
                     place_ff[cidx] <= htw_pkg::PLACE_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[hdl/htw_div.sv]
// Ceiling divider for the hashed timing wheel, one quotient bit per cycle.
// Depends on htw_pkg.
`timescale 1ns / 1ps
module htw_div (
   input  logic                 clock,
   input  logic                 reset,
   input  htw_pkg::div_cmd_type cmd,
   output logic                 busy,
   output logic [23:0]          quotient
);
   logic [24:0] rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in, num_ff, num_in;
   logic [15:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [24:0] trial;
   logic [24:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[23:0], num_ff[23]};
      trial   = shifted - {9'd0, den_ff};
      if (cmd.start) begin
         rem_in  = '0;
         quo_in  = '0;
         num_in  = cmd.dividend;
         den_in  = (cmd.divisor == 16'd0) ? 16'd1 : cmd.divisor;
         cnt_in  = 5'd24;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[22:0], 1'b0};
         if (!trial[24]) begin
            rem_in = trial;
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   // round up when a remainder is left
   assign quotient = quo_ff + {23'd0, (rem_ff != 25'd0)};
endmodule
